// ===== hdl/mcr_pkg.sv =====
// mcr_pkg: shared constants for the midpoint circle rasterizer
// command codes, fixed field widths; no dependencies
package mcr_pkg;

  localparam int PIX_BITS   = 13;
  localparam int COLOR_BITS = 24;
  localparam int PTS_PER_STEP = 8;
  localparam int PT_IDX_BITS  = 3;

  // func codes of an input item
  localparam logic FUNC_START = 1'b0;
  localparam logic FUNC_STEP  = 1'b1;

endpackage

// ===== hdl/mcr_front.sv =====
// mcr_front: input side of the rasterizer, classifies items and queues them
// two-entry command queue toward the walker; uses mcr_pkg
module mcr_front #(
  parameter int COORD_BITS = 11
) (
  input  logic                           clk,
  input  logic                           rst,
  // input channel
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           func,
  input  logic [COORD_BITS-1:0]          center_x,
  input  logic [COORD_BITS-1:0]          center_y,
  input  logic [COORD_BITS-1:0]          radius,
  input  logic [mcr_pkg::COLOR_BITS-1:0] draw_color,
  // command queue head
  output logic                           cmd_valid,
  input  logic                           cmd_pop,
  output logic                           cmd_start,
  output logic [COORD_BITS-1:0]          cmd_cx,
  output logic [COORD_BITS-1:0]          cmd_cy,
  output logic [COORD_BITS-1:0]          cmd_radius,
  output logic [mcr_pkg::COLOR_BITS-1:0] cmd_color
);

  logic                           q_start [2];
  logic [COORD_BITS-1:0]          q_cx    [2];
  logic [COORD_BITS-1:0]          q_cy    [2];
  logic [COORD_BITS-1:0]          q_rad   [2];
  logic [mcr_pkg::COLOR_BITS-1:0] q_color [2];

  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic [1:0] count_next;
  logic       push;
  logic       pop;

  assign in_stall  = (count == 2'd2);
  assign push      = in_valid && !in_stall;
  assign cmd_valid = (count != 2'd0);
  assign pop       = cmd_pop && cmd_valid;

  always_comb begin
    count_next = count;
    if (push && !pop) begin
      count_next = count + 2'd1;
    end else if (pop && !push) begin
      count_next = count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      count <= count_next;
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
    end
  end

  // payload entries, no reset needed
  always_ff @(posedge clk) begin
    if (push) begin
      q_start[wr_ptr] <= (func == mcr_pkg::FUNC_START);
      q_cx[wr_ptr]    <= center_x;
      q_cy[wr_ptr]    <= center_y;
      q_rad[wr_ptr]   <= radius;
      q_color[wr_ptr] <= draw_color;
    end
  end

  assign cmd_start  = q_start[rd_ptr];
  assign cmd_cx     = q_cx[rd_ptr];
  assign cmd_cy     = q_cy[rd_ptr];
  assign cmd_radius = q_rad[rd_ptr];
  assign cmd_color  = q_color[rd_ptr];

endmodule

// ===== hdl/mcr_back.sv =====
// mcr_back: octant walker and point emitter of the rasterizer
// pops commands from mcr_front, drives the registered output; uses mcr_pkg
module mcr_back #(
  parameter int COORD_BITS = 11
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // command queue head
  input  logic                                 cmd_valid,
  output logic                                 cmd_pop,
  input  logic                                 cmd_start,
  input  logic [COORD_BITS-1:0]                cmd_cx,
  input  logic [COORD_BITS-1:0]                cmd_cy,
  input  logic [COORD_BITS-1:0]                cmd_radius,
  input  logic [mcr_pkg::COLOR_BITS-1:0]       cmd_color,
  // output channel
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [mcr_pkg::PIX_BITS-1:0]  pixel_x,
  output logic signed [mcr_pkg::PIX_BITS-1:0]  pixel_y,
  output logic [mcr_pkg::COLOR_BITS-1:0]       out_color,
  output logic                                 last_point,
  output logic                                 circle_done
);

  localparam int DW = COORD_BITS + 3;
  localparam int WW = COORD_BITS + 2;
  localparam int EW = (COORD_BITS + 3 > mcr_pkg::PIX_BITS) ? COORD_BITS + 3
                                                            : mcr_pkg::PIX_BITS;

  logic [COORD_BITS-1:0]          oct_x;
  logic [COORD_BITS-1:0]          oct_y;
  logic [DW-1:0]                  decision;
  logic [COORD_BITS-1:0]          held_cx;
  logic [COORD_BITS-1:0]          held_cy;
  logic [mcr_pkg::COLOR_BITS-1:0] held_color;
  logic                           active;
  logic                           busy;
  logic [mcr_pkg::PT_IDX_BITS-1:0] idx;

  // walker update
  logic [DW-1:0]         x_d;
  logic [DW-1:0]         y_d;
  logic [DW-1:0]         decision_next;
  logic signed [WW-1:0]  x_inc;
  logic signed [WW-1:0]  y_new;
  logic                  done_now;
  logic [COORD_BITS-1:0] oct_x_next;
  logic [COORD_BITS-1:0] oct_y_next;

  assign x_d = {3'b000, oct_x};
  assign y_d = {3'b000, oct_y};

  always_comb begin
    x_inc = $signed({2'b00, oct_x}) + WW'(1);
    if (decision[DW-1]) begin
      decision_next = decision + (x_d << 1) + DW'(3);
      y_new         = $signed({2'b00, oct_y});
    end else begin
      decision_next = decision + ((x_d - y_d) << 1) + DW'(5);
      y_new         = $signed({2'b00, oct_y}) - WW'(1);
    end
    done_now   = (x_inc > y_new);
    oct_x_next = x_inc[COORD_BITS-1:0];
    // y only goes negative on the finishing step
    oct_y_next = y_new[WW-1] ? '0 : y_new[COORD_BITS-1:0];
  end

  // point of index idx
  logic [EW-1:0] cx_e;
  logic [EW-1:0] cy_e;
  logic [EW-1:0] off_a;
  logic [EW-1:0] off_b;
  logic [EW-1:0] px;
  logic [EW-1:0] py;
  logic          last_idx;

  always_comb begin
    cx_e  = {{(EW-COORD_BITS){1'b0}}, held_cx};
    cy_e  = {{(EW-COORD_BITS){1'b0}}, held_cy};
    // second half of the run swaps x and y
    off_a = idx[2] ? {{(EW-COORD_BITS){1'b0}}, oct_y} : {{(EW-COORD_BITS){1'b0}}, oct_x};
    off_b = idx[2] ? {{(EW-COORD_BITS){1'b0}}, oct_x} : {{(EW-COORD_BITS){1'b0}}, oct_y};
    px    = idx[0] ? (cx_e - off_a) : (cx_e + off_a);
    py    = idx[1] ? (cy_e - off_b) : (cy_e + off_b);
  end

  assign last_idx = (idx == mcr_pkg::PT_IDX_BITS'(mcr_pkg::PTS_PER_STEP - 1));

  logic load;
  logic last_load;
  logic active_after;

  assign load         = busy && (!out_valid || !out_stall);
  assign last_load    = load && last_idx;
  assign active_after = last_load ? (active && !done_now) : active;
  // next command may be taken in the cycle that the last point goes out
  assign cmd_pop      = cmd_valid && (!busy || last_load);

  always_ff @(posedge clk) begin
    if (rst) begin
      oct_x      <= '0;
      oct_y      <= '0;
      decision   <= '0;
      held_cx    <= '0;
      held_cy    <= '0;
      held_color <= '0;
      active     <= 1'b0;
      busy       <= 1'b0;
      idx        <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end

      if (load) begin
        idx <= idx + 1'b1;
      end

      if (last_load) begin
        oct_x    <= oct_x_next;
        oct_y    <= oct_y_next;
        decision <= decision_next;
        active   <= active && !done_now;
        busy     <= 1'b0;
      end

      if (cmd_pop) begin
        if (cmd_start) begin
          held_cx    <= cmd_cx;
          held_cy    <= cmd_cy;
          held_color <= cmd_color;
          oct_x      <= '0;
          oct_y      <= cmd_radius;
          decision   <= DW'(1) - {3'b000, cmd_radius};
          active     <= 1'b1;
          busy       <= 1'b0;
        end else begin
          // a step with no circle in progress is dropped
          busy <= active_after;
          idx  <= '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      pixel_x     <= px[mcr_pkg::PIX_BITS-1:0];
      pixel_y     <= py[mcr_pkg::PIX_BITS-1:0];
      out_color   <= held_color;
      last_point  <= last_idx;
      circle_done <= last_idx && done_now;
    end
  end

endmodule

// ===== hdl/midpoint_circle_rasterizer_core.sv =====
// midpoint_circle_rasterizer_core: top level of the circle rasterizer
// instantiates mcr_front and mcr_back; uses mcr_pkg
//
// Input channel (in_valid/in_stall) takes one item per accepted edge: func
// start loads center, radius and color; func step walks one octant point.
// Output channel (out_valid/out_stall) delivers plotted pixels, eight per
// step in mirror order, the eighth flagged last_point, and circle_done on
// the last point of the circle's final step. A step with no circle in
// progress yields nothing.
// Items go through a two-entry command queue, so the input keeps accepting
// while the walker is busy or the receiver stalls.
// With an idle walker, an accepted step goes from its queue entry to the
// walker's busy state and then to the output register, where its first pixel
// is valid. Its pixels pass in turn through the single output register, and
// the next command is taken as its last pixel is loaded; a start emits none.
// out_stall holds the output register and, once the queue fills, raises
// in_stall. Reset clears the queue, the output valid and the walker state
// (no circle in progress).
module midpoint_circle_rasterizer_core #(
  parameter int COORD_BITS = 11
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                func,
  input  logic [COORD_BITS-1:0]               center_x,
  input  logic [COORD_BITS-1:0]               center_y,
  input  logic [COORD_BITS-1:0]               radius,
  input  logic [mcr_pkg::COLOR_BITS-1:0]      draw_color,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [mcr_pkg::PIX_BITS-1:0] pixel_x,
  output logic signed [mcr_pkg::PIX_BITS-1:0] pixel_y,
  output logic [mcr_pkg::COLOR_BITS-1:0]      out_color,
  output logic                                last_point,
  output logic                                circle_done
);

  logic                           cmd_valid;
  logic                           cmd_pop;
  logic                           cmd_start;
  logic [COORD_BITS-1:0]          cmd_cx;
  logic [COORD_BITS-1:0]          cmd_cy;
  logic [COORD_BITS-1:0]          cmd_radius;
  logic [mcr_pkg::COLOR_BITS-1:0] cmd_color;

  mcr_front #(
    .COORD_BITS(COORD_BITS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .func       (func),
    .center_x   (center_x),
    .center_y   (center_y),
    .radius     (radius),
    .draw_color (draw_color),
    .cmd_valid  (cmd_valid),
    .cmd_pop    (cmd_pop),
    .cmd_start  (cmd_start),
    .cmd_cx     (cmd_cx),
    .cmd_cy     (cmd_cy),
    .cmd_radius (cmd_radius),
    .cmd_color  (cmd_color)
  );

  mcr_back #(
    .COORD_BITS(COORD_BITS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .cmd_valid   (cmd_valid),
    .cmd_pop     (cmd_pop),
    .cmd_start   (cmd_start),
    .cmd_cx      (cmd_cx),
    .cmd_cy      (cmd_cy),
    .cmd_radius  (cmd_radius),
    .cmd_color   (cmd_color),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .pixel_x     (pixel_x),
    .pixel_y     (pixel_y),
    .out_color   (out_color),
    .last_point  (last_point),
    .circle_done (circle_done)
  );

endmodule

// ===== sim/midpoint_circle_rasterizer_core_test.sv =====
// midpoint_circle_rasterizer_core_test: self-checking bench for the circle rasterizer
// drives start/step items, predicts the mirrored octant pixels and checks them in order
// depends on mcr_pkg and midpoint_circle_rasterizer_core
module midpoint_circle_rasterizer_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CW = 11;

  typedef struct {
    logic                           func;
    logic [CW-1:0]                  cx;
    logic [CW-1:0]                  cy;
    logic [CW-1:0]                  rad;
    logic [mcr_pkg::COLOR_BITS-1:0] color;
    bit                             drain_first;
  } cmd_t;

  typedef struct {
    logic signed [mcr_pkg::PIX_BITS-1:0] px;
    logic signed [mcr_pkg::PIX_BITS-1:0] py;
    logic [mcr_pkg::COLOR_BITS-1:0]      color;
    logic                                last;
    logic                                done;
  } pix_t;

  typedef enum int {RX_FREE, RX_LIGHT, RX_HEAVY, RX_TOGGLE} rx_mode_t;

  logic                                clk = 1'b0;
  logic                                rst = 1'b1;
  logic                                in_valid = 1'b0;
  logic                                in_stall;
  logic                                func = mcr_pkg::FUNC_START;
  logic [CW-1:0]                       center_x = '0;
  logic [CW-1:0]                       center_y = '0;
  logic [CW-1:0]                       radius = '0;
  logic [mcr_pkg::COLOR_BITS-1:0]      draw_color = '0;
  logic                                out_valid;
  logic                                out_stall = 1'b0;
  logic signed [mcr_pkg::PIX_BITS-1:0] pixel_x;
  logic signed [mcr_pkg::PIX_BITS-1:0] pixel_y;
  logic [mcr_pkg::COLOR_BITS-1:0]      out_color;
  logic                                last_point;
  logic                                circle_done;

  midpoint_circle_rasterizer_core #(.COORD_BITS(CW)) u_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .func       (func),
    .center_x   (center_x),
    .center_y   (center_y),
    .radius     (radius),
    .draw_color (draw_color),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .pixel_x    (pixel_x),
    .pixel_y    (pixel_y),
    .out_color  (out_color),
    .last_point (last_point),
    .circle_done(circle_done)
  );

  always #5 clk = ~clk;

  cmd_t pending_cmds[$];
  pix_t due_pixels[$];
  cmd_t cur_cmd;
  bit   in_took = 0;
  int   burst_left = 1;
  int   gap_left = 0;
  int   fail_count = 0;
  int   pix_seen = 0;
  int   starts_seen = 0;
  int   steps_seen = 0;
  int   circles_seen = 0;

  // walker state of the predicted circle
  logic [CW-1:0]                  walk_x = '0;
  logic [CW-1:0]                  walk_y = '0;
  logic signed [CW+2:0]           walk_d = '0;
  logic [CW-1:0]                  ctr_x = '0;
  logic [CW-1:0]                  ctr_y = '0;
  logic [mcr_pkg::COLOR_BITS-1:0] ctr_color = '0;
  bit                             drawing = 0;

  task automatic advance_circle(input cmd_t c);
    int   x, y, d, a, b;
    pix_t p;
    bit   fin;
    if (c.func == mcr_pkg::FUNC_START) begin
      ctr_x     = c.cx;
      ctr_y     = c.cy;
      ctr_color = c.color;
      walk_x    = '0;
      walk_y    = c.rad;
      walk_d    = (CW+3)'(1 - int'(c.rad));
      drawing   = 1;
    end else if (drawing) begin
      x = walk_x;
      y = walk_y;
      d = walk_d;
      if (d < 0) begin
        d += 2 * x + 3;
      end else begin
        d += 2 * (x - y) + 5;
        y--;
      end
      x++;
      fin = x > y;
      // mirror order: +-x about the column first, then the swapped octants
      for (int k = 0; k < mcr_pkg::PTS_PER_STEP; k++) begin
        a = (k >= 4) ? int'(walk_y) : int'(walk_x);
        b = (k >= 4) ? int'(walk_x) : int'(walk_y);
        p.px    = mcr_pkg::PIX_BITS'(int'(ctr_x) + ((k & 1) ? -a : a));
        p.py    = mcr_pkg::PIX_BITS'(int'(ctr_y) + ((k & 2) ? -b : b));
        p.color = ctr_color;
        p.last  = (k == mcr_pkg::PTS_PER_STEP - 1);
        p.done  = (k == mcr_pkg::PTS_PER_STEP - 1) && fin;
        due_pixels.push_back(p);
      end
      walk_x = CW'(x);
      walk_y = (y < 0) ? '0 : CW'(y);
      walk_d = (CW+3)'(d);
      if (fin) drawing = 0;
    end
  endtask

  task automatic queue_cmd(input logic f, input logic [CW-1:0] cx, input logic [CW-1:0] cy,
                           input logic [CW-1:0] r,
                           input logic [mcr_pkg::COLOR_BITS-1:0] color, input bit drain);
    cmd_t c;
    c.func        = f;
    c.cx          = cx;
    c.cy          = cy;
    c.rad         = r;
    c.color       = color;
    c.drain_first = drain;
    pending_cmds.push_back(c);
  endtask

  task automatic queue_step();
    queue_cmd(mcr_pkg::FUNC_STEP, CW'($urandom), CW'($urandom), CW'($urandom),
              mcr_pkg::COLOR_BITS'($urandom), 0);
  endtask

  // sender: bursts of items with random gaps
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_took) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (pending_cmds.size() == 0 ||
                   (pending_cmds[0].drain_first && due_pixels.size() != 0)) begin
        in_valid <= 1'b0;
      end else begin
        cur_cmd = pending_cmds.pop_front();
        func       <= cur_cmd.func;
        center_x   <= cur_cmd.cx;
        center_y   <= cur_cmd.cy;
        radius     <= cur_cmd.rad;
        draw_color <= cur_cmd.color;
        in_valid   <= 1'b1;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 30);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end
      end
    end
    in_took = 0;
  end

  // accepted items feed the predictor
  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall) begin
      advance_circle(cur_cmd);
      if (cur_cmd.func == mcr_pkg::FUNC_START) starts_seen++;
      else steps_seen++;
      in_took = 1;
    end
  end

  // receiver: stall pattern changes now and then, with long hold-offs
  rx_mode_t rx_mode = RX_FREE;
  int       mode_left = 0;
  int       hold_left = 0;
  int       hold_mark = 300;

  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (pix_seen >= hold_mark) begin
      hold_left = 400;
      hold_mark += 2500;
      out_stall <= 1'b1;
    end else begin
      if (mode_left == 0) begin
        rx_mode   = rx_mode_t'($urandom_range(0, 3));
        mode_left = $urandom_range(20, 200);
      end
      mode_left--;
      case (rx_mode)
        RX_FREE:  out_stall <= 1'b0;
        RX_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
        RX_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
        default:  out_stall <= ~out_stall;
      endcase
    end
  end

  // pixel checker
  always @(posedge clk) begin
    pix_t want;
    if (!rst && out_valid && !out_stall) begin
      pix_seen++;
      if (due_pixels.size() == 0) begin
        $error("unexpected pixel x=%0d y=%0d", pixel_x, pixel_y);
        fail_count++;
      end else begin
        want = due_pixels.pop_front();
        if (pixel_x !== want.px) begin
          $error("pixel_x: expected %0d, got %0d", want.px, pixel_x);
          fail_count++;
        end
        if (pixel_y !== want.py) begin
          $error("pixel_y: expected %0d, got %0d", want.py, pixel_y);
          fail_count++;
        end
        if (out_color !== want.color) begin
          $error("out_color: expected %h, got %h", want.color, out_color);
          fail_count++;
        end
        if (last_point !== want.last) begin
          $error("last_point: expected %b, got %b", want.last, last_point);
          fail_count++;
        end
        if (circle_done !== want.done) begin
          $error("circle_done: expected %b, got %b", want.done, circle_done);
          fail_count++;
        end
        if (want.done) circles_seen++;
      end
    end
  end

  initial begin
    int r, full, nsteps, queued, seq;
    queued = 0;
    seq = 0;

    // step with no circle, then radius zero, then a step after the circle ended
    queue_cmd(mcr_pkg::FUNC_STEP, '1, '1, '1, '1, 0);
    queue_cmd(mcr_pkg::FUNC_START, '0, '0, '0, '0, 0);
    queue_step();
    queue_step();
    // largest center and radius, abandoned by a new start
    queue_cmd(mcr_pkg::FUNC_START, '1, '1, '1, '1, 0);
    repeat (3) queue_step();
    queue_cmd(mcr_pkg::FUNC_START, '0, '1, 11'd1, 24'hA5A5A5, 0);
    queue_step();
    queue_step();
    // negative rows off screen
    queue_cmd(mcr_pkg::FUNC_START, 11'd1024, '0, '1, 24'h5A5A5A, 0);
    queue_step();
    queue_step();
    // small full circle once the block has drained
    queue_cmd(mcr_pkg::FUNC_START, 11'd5, 11'd7, 11'd10, 24'h123456, 1);
    repeat (9) queue_step();
    queued = pending_cmds.size();

    while (queued < 480) begin
      seq++;
      if ($urandom_range(0, 99) < 15) begin
        // noise: loose starts and steps in any order
        repeat ($urandom_range(1, 6)) begin
          queue_cmd(($urandom_range(0, 1) == 0) ? mcr_pkg::FUNC_START : mcr_pkg::FUNC_STEP,
                    CW'($urandom), CW'($urandom), CW'($urandom),
                    mcr_pkg::COLOR_BITS'($urandom), 0);
          queued++;
        end
      end else begin
        case ($urandom_range(0, 19))
          0:       r = $urandom_range(0, (1 << CW) - 1);
          1, 2:    r = $urandom_range(25, 120);
          default: r = $urandom_range(0, 24);
        endcase
        full = r * 707 / 1000 + 2;
        if (r > 120) nsteps = $urandom_range(1, 12);
        else if ($urandom_range(0, 4) == 0) nsteps = $urandom_range(0, full - 1);
        else nsteps = full + $urandom_range(0, 1);
        queue_cmd(mcr_pkg::FUNC_START, CW'($urandom), CW'($urandom), CW'(r),
                  mcr_pkg::COLOR_BITS'($urandom), (seq % 40 == 0));
        repeat (nsteps) queue_step();
        queued += 1 + nsteps;
      end
    end

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (pending_cmds.size() != 0 || in_valid) @(posedge clk);
    while (due_pixels.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("covered %0d starts and %0d steps: %0d pixels checked, %0d circles finished",
             starts_seen, steps_seen, pix_seen, circles_seen);
    if (fail_count == 0 && due_pixels.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #3ms;
    $display("Some tests failed");
    $finish;
  end

endmodule
